@@ rtl/osb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osb_pkg
// Shared types, constants and width helpers of the overlap seam blender.
// ----------------------------------------------------------------------------
package osb_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int COL_W         = 12;
	localparam int START_W       = 12;
	localparam int LWIDTH_W      = 13;
	localparam int CFG_DATA_W    = 13;
	localparam int CFG_IDX_W     = 1;
	localparam int CHANNELS      = 3;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [START_W-1:0]  START_RST  = 12'd0;
	localparam logic [LWIDTH_W-1:0] LWIDTH_RST = 13'd4096;

	// channel lanes: red, green, blue from high to low
	typedef logic [CHANNELS-1:0][7:0] pix_t;

	typedef enum logic [1:0] {
		MODE_LEFT,
		MODE_WARPED,
		MODE_BLEND
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OVERLAP_START = 1'b0,
		REG_LEFT_WIDTH    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [START_W-1:0]  start;
		logic [LWIDTH_W-1:0] width;
	} osb_cfg_t;

	typedef struct packed {
		mode_t            mode;
		logic [COL_W-1:0] k;
		pix_t             left;
		pix_t             warped;
	} osb_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic int span_width(input int max_w);
		int w;
		w = $clog2(max_w + 1);
		return (w > LWIDTH_W) ? LWIDTH_W : w;
	endfunction

	function automatic int num_width(input int max_w);
		return span_width(max_w) + 8;
	endfunction

	function automatic int recip_width(input int max_w);
		return num_width(max_w) + 1;
	endfunction

endpackage
`default_nettype wire

@@ rtl/osb_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osb_if
// Stream interfaces of the overlap seam blender: pixel pair in, pixel out.
// ----------------------------------------------------------------------------
interface osb_in_if;
	logic       valid;
	logic       ready;
	logic [11:0] column;
	logic [7:0] left_red;
	logic [7:0] left_green;
	logic [7:0] left_blue;
	logic [7:0] warped_red;
	logic [7:0] warped_green;
	logic [7:0] warped_blue;

	modport source (
		output valid, column, left_red, left_green, left_blue,
		output warped_red, warped_green, warped_blue,
		input  ready
	);
	modport sink (
		input  valid, column, left_red, left_green, left_blue,
		input  warped_red, warped_green, warped_blue,
		output ready
	);
endinterface

interface osb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (
		output valid, out_red, out_green, out_blue,
		input  ready
	);
	modport sink (
		input  valid, out_red, out_green, out_blue,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/overlap_seam_linear_blend_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overlap_seam_linear_blend_top
// Linear feather blend of left and warped pixels across the overlap seam.
// ----------------------------------------------------------------------------
// result path: an accepted input is written to the queue, then registered through stages s1 to s5
// throughput: one pixel per cycle, set by the five-stage blend pipeline,
// while out_ch.ready is high and the reciprocal divider is idle; after reset
// and after every configuration write the divider runs with in_ch.ready low
// reset: overlap_start 0, left_width 4096, queue and pipeline empty
// ----------------------------------------------------------------------------
module overlap_seam_linear_blend_top import osb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	osb_in_if.sink                in_ch,
	osb_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SPAN_W  = span_width(MAX_WIDTH);
	localparam int RECIP_W = recip_width(MAX_WIDTH);
	localparam int CMP_W   = 16;

	logic [START_W-1:0]  start_q;
	logic [LWIDTH_W-1:0] lwidth_q;
	logic [LWIDTH_W-1:0] width_c;
	logic [LWIDTH_W-1:0] span_full;
	logic [SPAN_W-1:0]   span;
	logic [RECIP_W-1:0]  recip;
	logic                recip_busy;
	osb_cfg_t            cfg;
	osb_item_t           push_item;
	osb_item_t           pop_item;
	logic                push;
	logic                pop;
	q_status_t           q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= START_RST;
			lwidth_q <= LWIDTH_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_OVERLAP_START: start_q  <= cfg_data[START_W-1:0];
				REG_LEFT_WIDTH:    lwidth_q <= cfg_data[LWIDTH_W-1:0];
			endcase
		end
	end

	// clamp to the widest supported image
	assign width_c   = (CMP_W'(lwidth_q) > CMP_W'(MAX_WIDTH)) ? LWIDTH_W'(MAX_WIDTH) : lwidth_q;
	assign span_full = width_c - {1'b0, start_q};
	assign span      = span_full[SPAN_W-1:0];
	assign cfg.start = start_q;
	assign cfg.width = width_c;

	osb_recip #(.MAX_WIDTH(MAX_WIDTH)) u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_we),
		.span   (span),
		.busy   (recip_busy),
		.recip  (recip)
	);

	osb_front u_front (
		.cfg        (cfg),
		.recip_busy (recip_busy),
		.in_ch      (in_ch),
		.q_status   (q_status),
		.push       (push),
		.item       (push_item)
	);

	osb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	osb_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.span     (span),
		.recip    (recip),
		.q_item   (pop_item),
		.q_status (q_status),
		.pop      (pop),
		.out_ch   (out_ch)
	);

endmodule
`default_nettype wire

@@ rtl/osb_recip.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osb_recip
// Bit-serial restoring divider: floor(2^SHIFT / span), one bit per cycle.
// ----------------------------------------------------------------------------
module osb_recip import osb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [span_width(MAX_WIDTH)-1:0]  span,
	output logic                              busy,
	output logic [recip_width(MAX_WIDTH)-1:0] recip
);

	localparam int SPAN_W  = span_width(MAX_WIDTH);
	localparam int RECIP_W = recip_width(MAX_WIDTH);
	localparam int SHIFT   = RECIP_W - 1;
	localparam int CNT_W   = $clog2(RECIP_W);
	localparam int AW      = RECIP_W + SPAN_W + 1;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SPAN_W-1:0] rem_q;
	logic [RECIP_W-1:0] quo_q;
	logic [SPAN_W:0]   trial;
	logic              qbit;
	logic [SPAN_W:0]   diff;

	// dividend is a single one at the top bit
	assign trial = {rem_q, (cnt_q == CNT_W'(SHIFT))};
	assign qbit  = (trial >= {1'b0, span});
	assign diff  = trial - {1'b0, span};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(SHIFT);
			rem_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(SHIFT);
			rem_q  <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && !start) begin
			quo_q <= {quo_q[RECIP_W-2:0], qbit};
		end
	end

	assign busy  = busy_q;
	assign recip = quo_q;

	logic [AW-1:0] lo_chk;
	logic [AW-1:0] hi_chk;
	assign lo_chk = AW'(quo_q) * AW'(span);
	assign hi_chk = (AW'(quo_q) + AW'(1)) * AW'(span);

	a_recip_exact: assert property (@(posedge clk) disable iff (!arst_n)
		($fell(busy_q) && (span != '0)) |->
			((lo_chk <= (AW'(1) << SHIFT)) && (hi_chk > (AW'(1) << SHIFT))))
		else $error("reciprocal not floor of 2^SHIFT / span");

endmodule
`default_nettype wire

@@ rtl/osb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osb_front
// Accepts pixel pairs and classifies them as left, warped or blend.
// ----------------------------------------------------------------------------
module osb_front import osb_pkg::*; (
	input  osb_cfg_t   cfg,
	input  logic       recip_busy,
	osb_in_if.sink     in_ch,
	input  q_status_t  q_status,
	output logic       push,
	output osb_item_t  item
);

	logic [LWIDTH_W-1:0] col_ext;
	pix_t                left_pix;
	pix_t                warped_pix;

	assign col_ext    = {1'b0, in_ch.column};
	assign left_pix   = {in_ch.left_red, in_ch.left_green, in_ch.left_blue};
	assign warped_pix = {in_ch.warped_red, in_ch.warped_green, in_ch.warped_blue};

	assign in_ch.ready = !recip_busy && !q_status.full;
	assign push        = in_ch.valid && in_ch.ready;

	always_comb begin
		item.k      = in_ch.column - cfg.start;
		item.left   = left_pix;
		item.warped = warped_pix;
		priority if (col_ext >= cfg.width) begin
			item.mode = MODE_WARPED;
		end else if (in_ch.column < cfg.start) begin
			item.mode = MODE_LEFT;
		end else if (warped_pix == '0) begin
			item.mode = MODE_LEFT;
		end else begin
			item.mode = MODE_BLEND;
		end
	end

endmodule
`default_nettype wire

@@ rtl/osb_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osb_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module osb_queue import osb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  osb_item_t push_item,
	input  logic      pop,
	output osb_item_t pop_item,
	output q_status_t status
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	osb_item_t        entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	assign pop_item     = entries_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_W'(QUEUE_DEPTH)))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue pop while empty");

endmodule
`default_nettype wire

@@ rtl/osb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osb_back
// Blend pipeline: weighted sums, reciprocal multiply, one-step correction.
// ----------------------------------------------------------------------------
module osb_back import osb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [span_width(MAX_WIDTH)-1:0]  span,
	input  logic [recip_width(MAX_WIDTH)-1:0] recip,
	input  osb_item_t                         q_item,
	input  q_status_t                         q_status,
	output logic                              pop,
	osb_out_if.source                         out_ch
);

	localparam int SPAN_W  = span_width(MAX_WIDTH);
	localparam int NUM_W   = num_width(MAX_WIDTH);
	localparam int RECIP_W = recip_width(MAX_WIDTH);
	localparam int SHIFT   = NUM_W;
	localparam int PROD_W  = NUM_W + RECIP_W;

	logic                en;
	logic [LWIDTH_W-1:0] k_ext;
	logic [SPAN_W-1:0]   kk;
	logic [SPAN_W-1:0]   wk;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic blend_s1, blend_s2, blend_s3, blend_s4;
	pix_t byp_s1, byp_s2, byp_s3, byp_s4;
	pix_t pix_s5;

	logic [NUM_W-1:0]  a_s1  [CHANNELS];
	logic [NUM_W-1:0]  b_s1  [CHANNELS];
	logic [NUM_W-1:0]  n_s2  [CHANNELS];
	logic [NUM_W-1:0]  n_s3  [CHANNELS];
	logic [7:0]        q0_s3 [CHANNELS];
	logic [NUM_W-1:0]  n_s4  [CHANNELS];
	logic [NUM_W-1:0]  m_s4  [CHANNELS];
	logic [7:0]        q0_s4 [CHANNELS];
	logic [PROD_W-1:0] prod  [CHANNELS];
	logic [NUM_W-1:0]  rem   [CHANNELS];
	pix_t              qpix;

	assign en    = !vld_s5 || out_ch.ready;
	assign pop   = en && !q_status.empty;
	assign k_ext = {1'b0, q_item.k};
	assign kk    = k_ext[SPAN_W-1:0];
	assign wk    = span - kk;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			prod[c] = PROD_W'(n_s2[c]) * PROD_W'(recip);
			rem[c]  = n_s4[c] - m_s4[c];
			qpix[c] = (rem[c] >= NUM_W'(span)) ? q0_s4[c] + 8'd1 : q0_s4[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= !q_status.empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blend_s1 <= (q_item.mode == MODE_BLEND);
			byp_s1   <= (q_item.mode == MODE_WARPED) ? q_item.warped : q_item.left;
			blend_s2 <= blend_s1;
			byp_s2   <= byp_s1;
			blend_s3 <= blend_s2;
			byp_s3   <= byp_s2;
			blend_s4 <= blend_s3;
			byp_s4   <= byp_s3;
			pix_s5   <= blend_s4 ? qpix : byp_s4;
			for (int c = 0; c < CHANNELS; c++) begin
				a_s1[c]  <= NUM_W'(q_item.left[c]) * NUM_W'(wk);
				b_s1[c]  <= NUM_W'(q_item.warped[c]) * NUM_W'(kk);
				n_s2[c]  <= a_s1[c] + b_s1[c];
				n_s3[c]  <= n_s2[c];
				q0_s3[c] <= prod[c][SHIFT+7:SHIFT];
				n_s4[c]  <= n_s3[c];
				q0_s4[c] <= q0_s3[c];
				m_s4[c]  <= NUM_W'(q0_s3[c]) * NUM_W'(span);
			end
		end
	end

	assign out_ch.valid     = vld_s5;
	assign out_ch.out_red   = pix_s5[2];
	assign out_ch.out_green = pix_s5[1];
	assign out_ch.out_blue  = pix_s5[0];

	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vld_s5) |-> $past(vld_s4))
		else $error("output valid without a transaction in the last stage");

endmodule
`default_nettype wire
